### hw/rtl/mlqs_pkg.sv
// Shared types and constants for the multilevel queue scheduler.
// No dependencies.
package mlqs_pkg;

	localparam logic [1:0] CLS_HIGH = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_LOW  = 2'd2;

	localparam logic [1:0] REG_QUANTUM_HIGH = 2'd0;
	localparam logic [1:0] REG_QUANTUM_MID  = 2'd1;
	localparam logic [1:0] REG_HIGH_MAX     = 2'd2;
	localparam logic [1:0] REG_MID_MAX      = 2'd3;

	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RD    = 6'b000010,
		ST_SETL  = 6'b000100,
		ST_PICK  = 6'b001000,
		ST_PRD   = 6'b010000,
		ST_RUN   = 6'b100000
	} state_t;

endpackage

### hw/rtl/mlqs_queue_mem.sv
// Queue storage for the three classes: one memory, class in the upper address bits.
// Depends on nothing but its parameters.
module mlqs_queue_mem #(
	parameter int SLOTS = 64,
	parameter int SW = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [1:0]          wcls,
	input  logic [SW-1:0]       waddr,
	input  logic [SW-1:0]       wdata,
	input  logic [1:0]          rcls,
	input  logic [SW-1:0]       raddr,
	output logic [SW-1:0]       rdata
);
	localparam int AW = $clog2(3*SLOTS);

	logic [SW-1:0] mem [3*SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[AW'(wcls) * AW'(SLOTS) + AW'(waddr)] <= wdata;
		rdata <= mem[AW'(rcls) * AW'(SLOTS) + AW'(raddr)];
	end
endmodule

### hw/rtl/mlqs_proc_mem.sv
// Per-slot process record memory: remaining, burst, class, arrival, first run, run flag.
// Depends on nothing but its parameters.
module mlqs_proc_mem #(
	parameter int SLOTS = 64,
	parameter int SW = 6,
	parameter int W = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [SW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [SW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/multilevel_queue_scheduler.sv
// Top level of the multilevel queue scheduler: control sequencer and statistics.
// Depends on mlqs_pkg, mlqs_queue_mem and mlqs_proc_mem.
//
// An arrival is taken in the cycle it is offered and keeps busy low, so arrivals can
// follow each other with no gap. A tick steps through ST_RD, ST_SETL, ST_PICK, ST_PRD
// and ST_RUN when a new slot is taken from a queue, and skips ST_PRD when the running
// slot continues or the tick is idle; reads of the process record and queue memory are
// registered and dependent. Busy is high in all states but ST_IDLE. A tick gives one
// result with strobe high for one cycle, in the first cycle with busy low; an arrival
// gives none. Results cannot be held off. An arrival whose queue is full is not queued.
module multilevel_queue_scheduler #(
	parameter int SLOTS = 64,
	parameter int TIME_BITS = 32,
	parameter int BURST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [5:0]  proc_id,
	input  logic [3:0]  priority_req,
	input  logic [15:0] burst_time,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        strobe,
	output logic [5:0]  run_id,
	output logic        idle,
	output logic        finished,
	output logic [31:0] turnaround_time,
	output logic [31:0] waiting_time,
	output logic [31:0] response_time,
	output logic [31:0] context_switches,
	output logic [31:0] idle_total
);
	localparam int SW = $clog2(SLOTS);
	localparam int CW = SW + 1;
	localparam int RW = 2*BURST_BITS + 2 + 2*TIME_BITS + 1;
	localparam logic [CW-1:0] FULL = CW'(SLOTS);

	typedef struct packed {
		logic [BURST_BITS-1:0] rem;
		logic [BURST_BITS-1:0] burst;
		logic [1:0]            cls;
		logic [TIME_BITS-1:0]  arr;
		logic [TIME_BITS-1:0]  first;
		logic                  ran;
	} rec_t;

	mlqs_pkg::state_t state_q;
	logic [7:0] qh_q, qm_q;
	logic [3:0] hmax_q, mmax_q;
	logic [SW-1:0] head_q [3];
	logic [CW-1:0] cnt_q [3];
	logic [SW-1:0] run_q, last_q;
	logic run_v_q, last_v_q;
	logic [7:0] slice_q;
	logic [TIME_BITS-1:0] now_q;
	logic [31:0] sw_q, idc_q;

	logic q_we;
	logic [1:0] q_wcls, q_rcls;
	logic [SW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
	logic p_we;
	logic [SW-1:0] p_waddr, p_raddr;
	rec_t p_wdata, p_rdata, rec;
	logic [RW-1:0] p_rraw;

	mlqs_queue_mem #(.SLOTS(SLOTS), .SW(SW)) u_qmem (
		.clk, .we(q_we), .wcls(q_wcls), .waddr(q_waddr), .wdata(q_wdata),
		.rcls(q_rcls), .raddr(q_raddr), .rdata(q_rdata));
	mlqs_proc_mem #(.SLOTS(SLOTS), .SW(SW), .W(RW)) u_pmem (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr),
		.rdata(p_rraw));
	assign p_rdata = rec_t'(p_rraw);

	logic [1:0] acls, rcls;
	logic back, pick_any;
	logic [1:0] pick_c;
	logic [BURST_BITS-1:0] rem_n;
	logic [TIME_BITS-1:0] now_n, first_n, tat, rt;
	logic [TIME_BITS:0] wt_d;
	logic [SW-1:0] s_in;
	logic [7:0] qh_e, qm_e;
	logic [CW-1:0] tail_a, tail_r;
	logic [SW-1:0] head_nx;

	assign s_in = SW'(proc_id);
	assign acls = (priority_req <= hmax_q) ? mlqs_pkg::CLS_HIGH :
		(priority_req <= mmax_q) ? mlqs_pkg::CLS_MID : mlqs_pkg::CLS_LOW;
	assign rcls = (p_rdata.cls == 2'd3) ? mlqs_pkg::CLS_HIGH : p_rdata.cls;
	assign qh_e = (qh_q == 8'd0) ? 8'd1 : qh_q;
	assign qm_e = (qm_q == 8'd0) ? 8'd1 : qm_q;

	always_comb begin
		back = 1'b0;
		if (rcls == mlqs_pkg::CLS_HIGH && slice_q >= qh_e) back = 1'b1;
		if (rcls == mlqs_pkg::CLS_MID && slice_q >= qm_e) back = 1'b1;
		if (rcls != mlqs_pkg::CLS_HIGH && cnt_q[0] != '0) back = 1'b1;
		if (rcls == mlqs_pkg::CLS_LOW && cnt_q[1] != '0) back = 1'b1;
		pick_any = 1'b1;
		if (cnt_q[0] != '0) pick_c = mlqs_pkg::CLS_HIGH;
		else if (cnt_q[1] != '0) pick_c = mlqs_pkg::CLS_MID;
		else begin
			pick_c = mlqs_pkg::CLS_LOW;
			pick_any = (cnt_q[2] != '0);
		end
		tail_a = CW'(head_q[acls]) + cnt_q[acls];
		if (tail_a >= FULL) tail_a = tail_a - FULL;
		tail_r = CW'(head_q[rcls]) + cnt_q[rcls];
		if (tail_r >= FULL) tail_r = tail_r - FULL;
		head_nx = (head_q[pick_c] == SW'(SLOTS-1)) ? '0 : head_q[pick_c] + 1'b1;
		rec = p_rdata;
		first_n = p_rdata.ran ? p_rdata.first : now_q;
		rem_n = (p_rdata.rem != '0) ? p_rdata.rem - 1'b1 : '0;
		now_n = now_q + 1'b1;
		tat = now_n - p_rdata.arr;
		wt_d = {1'b0, tat} - (TIME_BITS+1)'(p_rdata.burst);
		rt = first_n - p_rdata.arr;
		rec.rem = rem_n;
		rec.first = first_n;
		rec.ran = 1'b1;
	end

	always_comb begin
		q_we = 1'b0; q_wcls = acls; q_waddr = tail_a[SW-1:0]; q_wdata = s_in;
		q_rcls = pick_c; q_raddr = head_q[pick_c];
		p_we = 1'b0; p_waddr = s_in; p_raddr = run_q;
		p_wdata = '{rem: BURST_BITS'(burst_time), burst: BURST_BITS'(burst_time),
			cls: acls, arr: now_q, first: now_q, ran: 1'b0};
		case (state_q)
			mlqs_pkg::ST_IDLE: begin
				if (start && req_type == mlqs_pkg::REQ_ARRIVAL && 32'(proc_id) < SLOTS) begin
					p_we = 1'b1;
					q_we = (cnt_q[acls] < FULL);
				end
			end
			mlqs_pkg::ST_SETL: begin
				q_wcls = rcls;
				q_waddr = tail_r[SW-1:0];
				q_wdata = run_q;
				q_we = run_v_q && back && (cnt_q[rcls] < FULL);
			end
			mlqs_pkg::ST_PRD: p_raddr = q_rdata;
			mlqs_pkg::ST_RUN: begin
				p_we = run_v_q;
				p_waddr = run_q;
				p_wdata = rec;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlqs_pkg::ST_IDLE;
			qh_q <= 8'd2; qm_q <= 8'd4; hmax_q <= 4'd2; mmax_q <= 4'd4;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0; cnt_q[i] <= '0;
			end
			run_q <= '0; run_v_q <= 1'b0; last_q <= '0; last_v_q <= 1'b0;
			slice_q <= '0; now_q <= '0; sw_q <= '0; idc_q <= '0;
			strobe <= 1'b0;
			run_id <= '0; idle <= 1'b0; finished <= 1'b0;
			turnaround_time <= '0; waiting_time <= '0; response_time <= '0;
		end else begin
			strobe <= (state_q == mlqs_pkg::ST_RUN);
			if (cfg_we) begin
				case (cfg_index)
					mlqs_pkg::REG_QUANTUM_HIGH: qh_q <= cfg_data;
					mlqs_pkg::REG_QUANTUM_MID:  qm_q <= cfg_data;
					mlqs_pkg::REG_HIGH_MAX:     hmax_q <= cfg_data[3:0];
					mlqs_pkg::REG_MID_MAX:      mmax_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				mlqs_pkg::ST_IDLE: begin
					if (start) begin
						if (req_type == mlqs_pkg::REQ_TICK)
							state_q <= mlqs_pkg::ST_RD;
						else if (32'(proc_id) < SLOTS && cnt_q[acls] < FULL)
							cnt_q[acls] <= cnt_q[acls] + 1'b1;
					end
				end
				mlqs_pkg::ST_RD: state_q <= mlqs_pkg::ST_SETL;
				mlqs_pkg::ST_SETL: begin
					if (run_v_q && back) begin
						run_v_q <= 1'b0;
						if (cnt_q[rcls] < FULL) cnt_q[rcls] <= cnt_q[rcls] + 1'b1;
					end
					state_q <= mlqs_pkg::ST_PICK;
				end
				mlqs_pkg::ST_PICK: begin
					if (run_v_q) begin
						state_q <= mlqs_pkg::ST_RUN;
					end else if (pick_any) begin
						head_q[pick_c] <= head_nx;
						cnt_q[pick_c] <= cnt_q[pick_c] - 1'b1;
						state_q <= mlqs_pkg::ST_PRD;
					end else begin
						state_q <= mlqs_pkg::ST_RUN;
					end
				end
				mlqs_pkg::ST_PRD: begin
					run_q <= q_rdata;
					run_v_q <= 1'b1;
					slice_q <= '0;
					state_q <= mlqs_pkg::ST_RUN;
				end
				mlqs_pkg::ST_RUN: begin
					now_q <= now_n;
					if (!run_v_q) begin
						idle <= 1'b1; run_id <= '0; finished <= 1'b0;
						turnaround_time <= '0; waiting_time <= '0; response_time <= '0;
						if (idc_q != '1) idc_q <= idc_q + 1'b1;
					end else begin
						idle <= 1'b0; run_id <= 6'(run_q);
						if (last_v_q && last_q != run_q && sw_q != '1) sw_q <= sw_q + 1'b1;
						last_q <= run_q; last_v_q <= 1'b1;
						if (slice_q != 8'hFF) slice_q <= slice_q + 1'b1;
						finished <= (rem_n == '0);
						run_v_q <= (rem_n != '0);
						turnaround_time <= (rem_n == '0) ? 32'(tat) : 32'd0;
						waiting_time <= (rem_n == '0 && !wt_d[TIME_BITS]) ?
							32'(wt_d[TIME_BITS-1:0]) : 32'd0;
						response_time <= (rem_n == '0) ? 32'(rt) : 32'd0;
					end
					state_q <= mlqs_pkg::ST_IDLE;
				end
				default: state_q <= mlqs_pkg::ST_IDLE;
			endcase
		end
	end

	// keep record read of running slot aligned: ST_PICK with a kept slot reads run_q
	assign busy = (state_q != mlqs_pkg::ST_IDLE);
	assign context_switches = sw_q;
	assign idle_total = idc_q;

`ifndef NO_ASSERTIONS
	a_strobe_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == mlqs_pkg::ST_RUN) else $error("strobe without run");
	a_idle_no_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && idle |-> !finished) else $error("idle tick finished");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= FULL && cnt_q[1] <= FULL && cnt_q[2] <= FULL) else $error("count overflow");
`endif
endmodule

### sim/testbench.sv
// Self-checking testbench for multilevel_queue_scheduler: a queue-fed driver, a result
// monitor and a per-request predictor of the three-class scheduler. Depends on mlqs_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        kind;
		logic [5:0]  slot;
		logic [3:0]  prio;
		logic [15:0] burst;
	} sched_item_t;

	typedef struct packed {
		logic [5:0]  run_id;
		logic        idle;
		logic        finished;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [31:0] response;
		logic [31:0] switches;
		logic [31:0] idles;
	} tick_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        req_type = mlqs_pkg::REQ_ARRIVAL;
	logic [5:0]  proc_id = '0;
	logic [3:0]  priority_req = '0;
	logic [15:0] burst_time = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        strobe;
	logic [5:0]  run_id;
	logic        idle;
	logic        finished;
	logic [31:0] turnaround_time;
	logic [31:0] waiting_time;
	logic [31:0] response_time;
	logic [31:0] context_switches;
	logic [31:0] idle_total;

	multilevel_queue_scheduler dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sched_item_t  pending_items[$];
	tick_report_t expected_reports[$];
	sched_item_t  cur_item;
	int           gap_left = 0;
	bit           no_gaps = 0;
	bit           load_next;
	int           mismatches = 0;
	int           cycles = 0;

	// scheduler state mirror
	logic [7:0]  qnt_high = 8'd2, qnt_mid = 8'd4;
	logic [3:0]  max_high = 4'd2, max_mid = 4'd4;
	logic [5:0]  class_fifo[3][64];
	logic [5:0]  fifo_head[3];
	logic [6:0]  fifo_count[3];
	logic [15:0] remain[64];
	logic [15:0] burst_of[64];
	logic [1:0]  class_of[64];
	logic [31:0] arrived_at[64];
	logic [31:0] first_ran[64];
	bit          has_run[64];
	logic [5:0]  cur_slot = '0;
	bit          cur_valid = 0;
	logic [7:0]  slice = '0;
	logic [31:0] now = '0;
	logic [5:0]  last_slot = '0;
	bit          last_valid = 0;
	logic [31:0] switch_cnt = '0, idle_cnt = '0;

	initial begin
		for (int c = 0; c < 3; c++) begin
			fifo_head[c] = '0;
			fifo_count[c] = '0;
		end
	end

	function automatic void queue_item(input sched_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void enqueue(input logic [1:0] c, input logic [5:0] s);
		if (c > mlqs_pkg::CLS_LOW || fifo_count[c] >= 64)
			return;
		class_fifo[c][6'(fifo_head[c] + fifo_count[c])] = s;
		fifo_count[c]++;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	function automatic void schedule_step(input sched_item_t it);
		logic [1:0]   c;
		bit           back;
		tick_report_t r;
		if (it.kind == mlqs_pkg::REQ_ARRIVAL) begin
			c = (it.prio <= max_high) ? mlqs_pkg::CLS_HIGH :
				(it.prio <= max_mid) ? mlqs_pkg::CLS_MID : mlqs_pkg::CLS_LOW;
			remain[it.slot] = it.burst;
			burst_of[it.slot] = it.burst;
			class_of[it.slot] = c;
			arrived_at[it.slot] = now;
			has_run[it.slot] = 0;
			enqueue(c, it.slot);
			return;
		end
		if (cur_valid) begin
			c = class_of[cur_slot];
			back = 0;
			if (c == mlqs_pkg::CLS_HIGH && slice >= qnt_high) back = 1;
			if (c == mlqs_pkg::CLS_MID && slice >= qnt_mid) back = 1;
			if (c != mlqs_pkg::CLS_HIGH && fifo_count[mlqs_pkg::CLS_HIGH] != 0) back = 1;
			if (c == mlqs_pkg::CLS_LOW && fifo_count[mlqs_pkg::CLS_MID] != 0) back = 1;
			if (back) begin
				enqueue(c, cur_slot);
				cur_valid = 0;
			end
		end
		if (!cur_valid) begin
			for (int k = 0; k < 3; k++) begin
				if (!cur_valid && fifo_count[k] != 0) begin
					cur_slot = class_fifo[k][fifo_head[k]];
					fifo_head[k] = fifo_head[k] + 1;
					fifo_count[k]--;
					cur_valid = 1;
					slice = '0;
				end
			end
		end
		r = '{default: '0};
		if (!cur_valid) begin
			idle_cnt = sat_inc(idle_cnt);
			now = now + 1;
			r.idle = 1'b1;
		end else begin
			if (!has_run[cur_slot]) begin
				has_run[cur_slot] = 1;
				first_ran[cur_slot] = now;
			end
			if (last_valid && last_slot != cur_slot)
				switch_cnt = sat_inc(switch_cnt);
			last_slot = cur_slot;
			last_valid = 1;
			if (slice != 8'd255) slice++;
			if (remain[cur_slot] != 0) remain[cur_slot]--;
			now = now + 1;
			r.run_id = cur_slot;
			if (remain[cur_slot] == 0) begin
				cur_valid = 0;
				r.finished = 1'b1;
				r.turnaround = now - arrived_at[cur_slot];
				r.waiting = (r.turnaround >= burst_of[cur_slot]) ?
					r.turnaround - burst_of[cur_slot] : '0;
				r.response = first_ran[cur_slot] - arrived_at[cur_slot];
			end
		end
		r.switches = switch_cnt;
		r.idles = idle_cnt;
		expected_reports.insert(expected_reports.size(), r);
	endfunction

	function automatic sched_item_t make_item(input logic k, input int s, input int p,
			input int b);
		sched_item_t it;
		it.kind = k;
		it.slot = 6'(s);
		it.prio = 4'(p);
		it.burst = 16'(b);
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			load_next = 0;
			if (start && !busy) begin
				schedule_step(cur_item);
				g = pick_gap();
				gap_left <= g;
				if (g == 0)
					load_next = 1;
				else
					start <= 1'b0;
			end else if (!start) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else
					load_next = 1;
			end
			if (load_next) begin
				if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					req_type <= cur_item.kind;
					proc_id <= cur_item.slot;
					priority_req <= cur_item.prio;
					burst_time <= cur_item.burst;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		tick_report_t exp_r;
		tick_report_t act;
		if (arst_n && strobe) begin
			act = '{run_id, idle, finished, turnaround_time, waiting_time, response_time,
				context_switches, idle_total};
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tick report: run_id=%0d idle=%0b", run_id, idle);
			end else begin
				exp_r = expected_reports.pop_front();
				if (act != exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tick mismatch: exp %p, got %p", exp_r, act);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			mlqs_pkg::REG_QUANTUM_HIGH: qnt_high = v;
			mlqs_pkg::REG_QUANTUM_MID:  qnt_mid = v;
			mlqs_pkg::REG_HIGH_MAX:     max_high = v[3:0];
			mlqs_pkg::REG_MID_MAX:      max_mid = v[3:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !start && expected_reports.size() == 0);
		repeat (12) @(posedge clk);
		wait (!busy);
	endtask

	task automatic add_random(input int n);
		int b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 40) begin
				case ($urandom_range(0, 19))
					0:       b = 0;
					1:       b = $urandom_range(0, 65535);
					2, 3, 4: b = $urandom_range(1, 40);
					default: b = $urandom_range(1, 6);
				endcase
				queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, $urandom_range(0, 63),
					$urandom_range(0, 15), b));
			end else begin
				queue_item(make_item(mlqs_pkg::REQ_TICK, 0, 0, 0));
			end
		end
	endtask

	task automatic add_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_item(make_item(mlqs_pkg::REQ_TICK, 0, 0, 0));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, extremes, every class, zero burst, rearrival, preemption
		add_ticks(1);
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 63, 15, 65535));
		add_ticks(2);
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 0, 0, 0));
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 21, 4, 3));
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 42, 2, 5));
		add_ticks(4);
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 42, 3, 1));
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 21, 10, 2));
		add_ticks(6);
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 5, 1, 21845));
		queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, 5, 1, 43690));
		add_ticks(4);
		add_random(280);
		drain();

		write_reg(mlqs_pkg::REG_QUANTUM_HIGH, 8'd1);
		write_reg(mlqs_pkg::REG_QUANTUM_MID, 8'd1);
		write_reg(mlqs_pkg::REG_HIGH_MAX, 8'd0);
		write_reg(mlqs_pkg::REG_MID_MAX, 8'd15);
		no_gaps = 1;
		add_random(250);
		drain();

		write_reg(mlqs_pkg::REG_QUANTUM_HIGH, 8'd255);
		write_reg(mlqs_pkg::REG_QUANTUM_MID, 8'd255);
		write_reg(mlqs_pkg::REG_HIGH_MAX, 8'd15);
		write_reg(mlqs_pkg::REG_MID_MAX, 8'd0);
		no_gaps = 0;
		// overfill one queue so the last pushes drop
		for (int i = 0; i < 68; i++)
			queue_item(make_item(mlqs_pkg::REQ_ARRIVAL, i % 64, 7, 1));
		add_ticks(75);
		add_random(200);
		drain();

		write_reg(mlqs_pkg::REG_QUANTUM_HIGH, 8'd0);
		write_reg(mlqs_pkg::REG_QUANTUM_MID, 8'd0);
		write_reg(mlqs_pkg::REG_HIGH_MAX, 8'd7);
		write_reg(mlqs_pkg::REG_MID_MAX, 8'd9);
		add_random(200);
		drain();

		write_reg(mlqs_pkg::REG_QUANTUM_HIGH, 8'($urandom_range(1, 8)));
		write_reg(mlqs_pkg::REG_QUANTUM_MID, 8'($urandom_range(1, 8)));
		write_reg(mlqs_pkg::REG_HIGH_MAX, 8'($urandom_range(0, 15)));
		write_reg(mlqs_pkg::REG_MID_MAX, 8'($urandom_range(0, 15)));
		add_random(250);
		drain();

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

### filelist.f
hw/rtl/mlqs_pkg.sv
hw/rtl/mlqs_queue_mem.sv
hw/rtl/mlqs_proc_mem.sv
hw/rtl/multilevel_queue_scheduler.sv
sim/testbench.sv
